@@ design/lfba_pkg.sv @@
package lfba_pkg;

    localparam int NUM_HANDLES = 1024;
    localparam int MAX_BLOCK   = 64;
    localparam int HANDLE_W    = 10;
    localparam int LINK_W      = 11;
    localparam int COUNT_W     = 7;

    // link value with the top bit set marks the end of the list
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_HANDLES);

    typedef enum logic [1:0] {
        CMD_FREE      = 2'd0,
        CMD_ALLOC     = 2'd1,
        CMD_ALLOC_BLK = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted_handle;
        logic                granted;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic                wr_en;
        logic [HANDLE_W-1:0] wr_addr;
        logic [LINK_W-1:0]   wr_data;
        logic                rd_en;
        logic [HANDLE_W-1:0] rd_addr;
    } ram_ctl_t;

endpackage

@@ design/lfba_link_ram.sv @@
module lfba_link_ram (
    input  logic                          clk,
    input  lfba_pkg::ram_ctl_t            ctl,
    output logic [lfba_pkg::LINK_W-1:0]   rd_data
);
    import lfba_pkg::*;

    // next-pointer table, contents undefined until a free writes them
    logic [LINK_W-1:0] mem [NUM_HANDLES];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_addr];
        end
    end

endmodule

@@ design/linked_free_list_block_alloc.sv @@
// Linked free-list handle allocator with a 1024 x 11 next-pointer table.
// Free: accepted while idle, busy stays low, no result word.
// Alloc/block alloc: a table read, then a pop, per handle; an empty list or zero
// count gives one word in the next cycle.
// Results are one-cycle strobed words; the receiver cannot stall.
// Reset empties the list (head = null); the table itself is not cleared.
module linked_free_list_block_alloc (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lfba_pkg::req_t   req,
    output logic             rsp_valid,
    output lfba_pkg::rsp_t   rsp
);
    import lfba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,   // issue table read at the current head
        S_POP     // read data back: pop head, emit word
    } state_t;

    state_t              state_reg;
    logic [LINK_W-1:0]   head_reg;
    logic [COUNT_W-1:0]  remain_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    ram_ctl_t            ram_ctl;
    logic [LINK_W-1:0]   rd_data;

    logic                accept;
    logic                head_empty;
    logic [LINK_W-1:0]   link_next;   // fetched link, clamped to null
    logic                pop_last;
    logic [COUNT_W-1:0]  want;

    assign accept     = start && (state_reg == S_IDLE);
    assign head_empty = head_reg[LINK_W-1];
    assign link_next  = rd_data[LINK_W-1] ? LINK_NULL : rd_data;
    assign pop_last   = (remain_reg == COUNT_W'(1)) || link_next[LINK_W-1];

    // requested count: single alloc wants one, block alloc saturates
    always_comb
    begin
        if (req.command == CMD_ALLOC)
        begin
            want = COUNT_W'(1);
        end
        else if (req.count > COUNT_W'(MAX_BLOCK))
        begin
            want = COUNT_W'(MAX_BLOCK);
        end
        else
        begin
            want = req.count;
        end
    end

    // table port control
    always_comb
    begin
        ram_ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.command == CMD_FREE)
                begin
                    ram_ctl.wr_en   = 1'b1;
                    ram_ctl.wr_addr = req.handle;
                    ram_ctl.wr_data = head_reg;
                end
                ram_ctl.rd_en   = accept && !head_empty && want != '0 &&
                                  (req.command == CMD_ALLOC ||
                                   req.command == CMD_ALLOC_BLK);
                ram_ctl.rd_addr = head_reg[HANDLE_W-1:0];
            end
            S_READ:
            begin
                ram_ctl.rd_en   = 1'b1;
                ram_ctl.rd_addr = head_reg[HANDLE_W-1:0];
            end
            S_POP:
            begin
                // popped entry goes back to null
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_addr = head_reg[HANDLE_W-1:0];
                ram_ctl.wr_data = LINK_NULL;
            end
            default:
            begin
                ram_ctl = '0;
            end
        endcase
    end

    lfba_link_ram u_link_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= LINK_NULL;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.command)
                            CMD_FREE:
                            begin
                                head_reg <= {1'b0, req.handle};
                            end
                            CMD_ALLOC, CMD_ALLOC_BLK:
                            begin
                                if (head_empty || want == '0)
                                begin
                                    // single "none" word, list untouched
                                    rsp_valid_reg <= 1'b1;
                                    rsp_reg       <= '{granted_handle: '0,
                                                       granted: 1'b0,
                                                       last: 1'b1};
                                end
                                else
                                begin
                                    remain_reg <= want;
                                    state_reg  <= S_POP;
                                end
                            end
                            default:
                            begin
                                // unused code: ignored
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    rsp_valid_reg <= 1'b1;
                    rsp_reg       <= '{granted_handle: head_reg[HANDLE_W-1:0],
                                       granted: 1'b1,
                                       last: pop_last};
                    head_reg      <= link_next;
                    remain_reg    <= remain_reg - COUNT_W'(1);
                    state_reg     <= pop_last ? S_IDLE : S_READ;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // final word of a command always leaves the block free
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |-> !busy)
        else $error("last word while still busy");

    // a non-final word means more pops are pending
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> busy)
        else $error("non-final word with block idle");

    // "none" word is always final and carries handle zero
    a_none_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.granted |-> rsp.last && rsp.granted_handle == '0)
        else $error("malformed none word");

    // an accepted allocate either starts popping or answers next cycle
    a_alloc_resp: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy &&
        (req.command == CMD_ALLOC || req.command == CMD_ALLOC_BLK)
        |=> busy || rsp_valid)
        else $error("allocate dropped");

endmodule

@@ sim/linked_free_list_block_alloc_test.sv @@
`timescale 1ns / 1ps

module linked_free_list_block_alloc_test;
    import lfba_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic rsp_valid;
    rsp_t rsp;

    linked_free_list_block_alloc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Words waiting to be sent, and grants the list predicts in order.
    req_t pending_words[$];
    rsp_t expected_grants[$];
    int   error_count = 0;

    // Predicted free list: head pointer plus next-pointer table.
    logic [LINK_W-1:0] free_head = LINK_NULL;
    logic [LINK_W-1:0] next_free [NUM_HANDLES];

    // Driver pacing.
    logic taken = 1'b0;
    int   gap_left = 0;
    bit   steady = 1'b0;

    function automatic req_t make_word(cmd_t c, int h, int n);
        req_t w;
        w.command = c;
        w.handle  = HANDLE_W'(h);
        w.count   = COUNT_W'(n);
        return w;
    endfunction

    // Gap after each accepted word: mostly none or short, now and then long,
    // and whole stretches with no gaps at all.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pops the head of the predicted list; ok is low when the list is empty.
    task automatic pop_free(output bit ok, output logic [HANDLE_W-1:0] h);
        ok = 1'b0;
        h  = '0;
        if (free_head >= NUM_HANDLES) begin
            free_head = LINK_NULL;
        end
        else begin
            h = free_head[HANDLE_W-1:0];
            free_head = next_free[h];
            if (free_head > LINK_NULL)
                free_head = LINK_NULL;
            next_free[h] = LINK_NULL;
            ok = 1'b1;
        end
    endtask

    task automatic push_grant(logic [HANDLE_W-1:0] h, logic g, logic l);
        rsp_t e;
        e.granted_handle = h;
        e.granted        = g;
        e.last           = l;
        expected_grants.push_back(e);
    endtask

    // Updates the predicted list for one accepted word and queues its grants.
    task automatic grant_handles(req_t w);
        logic [HANDLE_W-1:0] h;
        bit ok;
        int want;
        int n;
        case (cmd_t'(w.command))
            CMD_FREE:
            begin
                next_free[w.handle] = free_head;
                free_head = {1'b0, w.handle};
            end
            CMD_ALLOC:
            begin
                pop_free(ok, h);
                push_grant(ok ? h : '0, ok, 1'b1);
            end
            CMD_ALLOC_BLK:
            begin
                want = (w.count > MAX_BLOCK) ? MAX_BLOCK : int'(w.count);
                if (want == 0 || free_head >= NUM_HANDLES) begin
                    push_grant('0, 1'b0, 1'b1);
                end
                else begin
                    n = 0;
                    ok = 1'b1;
                    while (n < want && ok) begin
                        pop_free(ok, h);
                        if (ok) begin
                            // last on the final requested handle or when the list runs dry
                            push_grant(h, 1'b1, (n + 1 == want) || (free_head >= NUM_HANDLES));
                            n++;
                        end
                    end
                end
            end
            default:
            begin
                // unused code: no grant, list untouched
            end
        endcase
    endtask

    task automatic report(string field, int unsigned exp_v, int unsigned act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        error_count++;
    endtask

    // Driver: inputs change on the falling edge. A word stays on the port
    // until the rising edge sees start with busy low.
    always @(negedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 19) == 0)
                steady <= !steady;
            if (!(start && !taken)) begin
                if (gap_left > 0) begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() > 0) begin
                    req <= pending_words.pop_front();
                    start <= 1'b1;
                    gap_left <= next_gap();
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor and acceptance, both on the rising edge. Grants are registered and come
    // after their word is taken, so checking before predicting is safe.
    always @(posedge clk) begin
        rsp_t e;
        if (rst_n) begin
            if (rsp_valid) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, rsp);
                    error_count++;
                end
                else begin
                    e = expected_grants.pop_front();
                    if (rsp.granted_handle !== e.granted_handle)
                        report("granted_handle", e.granted_handle, rsp.granted_handle);
                    if (rsp.granted !== e.granted)
                        report("granted", e.granted, rsp.granted);
                    if (rsp.last !== e.last)
                        report("last", e.last, rsp.last);
                end
            end
            if (start && !busy)
                grant_handles(req);
            taken <= start && !busy;
        end
    end

    // Stimulus. The list length is tracked here only to steer the mix.
    initial begin
        int list_len;
        int total;
        int r;
        int n;
        bit burst_done;

        // Directed part.
        pending_words.push_back(make_word(CMD_ALLOC, 0, 0));        // empty list, single
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 5));    // empty list, block
        pending_words.push_back(make_word(CMD_FREE, 0, 0));
        pending_words.push_back(make_word(CMD_FREE, 1023, 127));
        pending_words.push_back(make_word(CMD_FREE, 512, 0));
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 0));    // zero count, list kept
        pending_words.push_back(make_word(CMD_NOP, 1023, 127));     // ignored
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 1023, 2)); // 512 then 1023
        pending_words.push_back(make_word(CMD_ALLOC, 0, 0));        // 0
        pending_words.push_back(make_word(CMD_ALLOC, 0, 0));        // empty again
        pending_words.push_back(make_word(CMD_FREE, 7, 0));
        pending_words.push_back(make_word(CMD_FREE, 7, 0));         // double free
        pending_words.push_back(make_word(CMD_FREE, 300, 0));
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 127));  // saturates, list runs short
        pending_words.push_back(make_word(CMD_FREE, 1, 0));
        pending_words.push_back(make_word(CMD_FREE, 2, 0));
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 1));
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 64));   // list shorter than block
        pending_words.push_back(make_word(CMD_FREE, 5, 0));
        pending_words.push_back(make_word(CMD_FREE, 6, 0));
        pending_words.push_back(make_word(CMD_FREE, 5, 0));         // cycle through the links
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 10));
        pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 3));    // list empty again

        // Random part.
        list_len = 0;
        total = 0;
        burst_done = 1'b0;
        while (total < 180) begin
            if (!burst_done && total >= 70) begin
                // fill past MAX_BLOCK, then drain a full block and the rest
                while (list_len < 70) begin
                    pending_words.push_back(make_word(CMD_FREE, $urandom_range(0, 1023), 0));
                    list_len++;
                    total++;
                end
                pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, 64));
                pending_words.push_back(make_word(CMD_ALLOC_BLK, 0, $urandom_range(65, 127)));
                list_len = (list_len > 128) ? list_len - 128 : 0;
                total += 2;
                burst_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                pending_words.push_back(make_word(CMD_FREE, $urandom_range(0, 1023),
                                                  $urandom_range(0, 127)));
                list_len++;
            end
            else if (r < 65) begin
                pending_words.push_back(make_word(CMD_ALLOC, $urandom_range(0, 1023),
                                                  $urandom_range(0, 127)));
                if (list_len > 0)
                    list_len--;
            end
            else if (r < 93) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    n = $urandom_range(0, 8);
                else if (r < 90)
                    n = $urandom_range(9, 64);
                else
                    n = $urandom_range(65, 127);
                pending_words.push_back(make_word(CMD_ALLOC_BLK, $urandom_range(0, 1023), n));
                n = (n > MAX_BLOCK) ? MAX_BLOCK : n;
                list_len = (list_len > n) ? list_len - n : 0;
            end
            else begin
                pending_words.push_back(make_word(CMD_NOP, $urandom_range(0, 1023),
                                                  $urandom_range(0, 127)));
            end
            total++;
        end
    end

    // Reset, drain and final verdict.
    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        while (pending_words.size() != 0 || start || expected_grants.size() != 0)
            @(posedge clk);
        // longest block is 64 handles; catch stray words
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("linked_free_list_block_alloc_test: done, clean");
        else
            $display("linked_free_list_block_alloc_test: done, errors");
        $finish;
    end

    // Hang guard, well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("linked_free_list_block_alloc_test: done, errors");
        $finish;
    end

endmodule
